FILE: hw/rtl/rsi_pkg.sv
package rsi_pkg;

  // Number of root bits produced by the square root chain, one per stage.
  localparam int SqrtSteps = 64;
  // Quotient bits produced by each divider lane, one per stage.
  localparam int DivSteps = 33;

  localparam logic [30:0] RadiusReset = 31'd65536;
  localparam logic [31:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [31:0] SatNeg = 32'h8000_0000;

  // One stage of the square root chain with the ray data that rides along.
  typedef struct packed {
    logic               ok;
    logic               shadow;
    logic [63:0]        a;
    logic signed [65:0] b;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [127:0]       v;
    logic [65:0]        rem;
    logic [63:0]        root;
  } sq_t;

  // One divider lane: sign, early saturation, remaining dividend bits,
  // partial remainder and quotient.
  typedef struct packed {
    logic        neg;
    logic        sat;
    logic [32:0] bits;
    logic [63:0] rem;
    logic [32:0] q;
  } dlane_t;

  typedef struct packed {
    logic               ok;
    logic               shadow;
    logic [63:0]        a;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    dlane_t             l0;
    dlane_t             l1;
  } dv_t;

  // Restoring square root, one result bit per call.
  function automatic sq_t sqrt_step(input sq_t s);
    sq_t         r;
    logic [66:0] rw;
    logic [66:0] tr;
    r  = s;
    rw = {s.rem[64:0], s.v[127:126]};
    tr = {1'b0, s.root, 2'b01};
    r.v = {s.v[125:0], 2'b00};
    if (rw >= tr) begin
      r.rem  = 66'(rw - tr);
      r.root = {s.root[62:0], 1'b1};
    end else begin
      r.rem  = rw[65:0];
      r.root = {s.root[62:0], 1'b0};
    end
    return r;
  endfunction

  // Builds a divider lane from a signed numerator. The quotient of
  // |n| * 2^16 / a saturates when it would need more than 33 bits.
  function automatic dlane_t lane_init(input logic signed [67:0] n, input logic [63:0] a);
    dlane_t      l;
    logic [67:0] mag;
    mag    = n[67] ? 68'(-n) : n;
    l.neg  = n[67];
    l.rem  = {15'b0, mag[65:17]};
    l.sat  = l.rem >= a;
    l.bits = {mag[16:0], 16'b0};
    l.q    = '0;
    return l;
  endfunction

  // Restoring division, one quotient bit per call.
  function automatic dlane_t div_step(input dlane_t l, input logic [63:0] a);
    dlane_t      r;
    logic [64:0] rw;
    r      = l;
    rw     = {l.rem, l.bits[32]};
    r.bits = {l.bits[31:0], 1'b0};
    if (rw >= {1'b0, a}) begin
      r.rem = 64'(rw - {1'b0, a});
      r.q   = {l.q[31:0], 1'b1};
    end else begin
      r.rem = rw[63:0];
      r.q   = {l.q[31:0], 1'b0};
    end
    return r;
  endfunction

  // Floor of the signed quotient, saturated to Q16.16.
  function automatic logic [31:0] to_q16(input dlane_t l);
    logic [33:0] qq;
    qq = {1'b0, l.q} + {33'b0, (l.rem != 64'd0)};
    if (!l.neg) begin
      return (l.sat || l.q > 33'h0_7FFF_FFFF) ? SatPos : l.q[31:0];
    end
    return (l.sat || qq > 34'h0_8000_0000) ? SatNeg : 32'(~qq[31:0] + 32'd1);
  endfunction

endpackage

FILE: hw/rtl/ray_sphere_intersect.sv
// Ray against sphere intersection, signed Q16.16 fixed point.
// A request is accepted at a rising clock edge where start is high and busy
// is low. Busy never rises: the block is a fully pipelined datapath and takes
// one ray in every clock cycle, back to back, with no bubbles.
// Each request produces exactly one result. The result is on hit_o and
// hit_distance_o for one cycle, marked by done_o. A request passes through
// six multiplier and adder stages, the 64-stage square root chain, then
// the numerator and divider setup registers, the 33-stage divider lanes and
// finally the output register. The receiver cannot stall the block, so
// results simply leave in the order the requests came in.
// The sphere radius is written through the cfg channel, which is always
// ready. Write it only while no request is in flight.
// Reset clears every valid bit in the pipeline, so no stale result leaves
// after reset, and returns the radius to 1.0. Data registers are not reset.
// The hit distance is zero on a miss or when shadow_only_i was set.
module ray_sphere_intersect (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [30:0]        cfg_data_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic signed [31:0] near_limit_i,
  input  logic signed [31:0] far_limit_i,
  input  logic               shadow_only_i,
  output logic               done_o,
  output logic               hit_o,
  output logic signed [31:0] hit_distance_o
);
  import rsi_pkg::*;

  logic [30:0] radius_q;
  logic        accept;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radius_q <= cfg_data_i;
    end
  end

  // Valid bits for every stage.
  logic                  v1_q, v2_q, v3_q, v4_q, v5_q, nm_vld_q, done_q;
  logic [SqrtSteps:0]    sq_vld_q;
  logic [DivSteps:0]     dv_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      v5_q     <= 1'b0;
      sq_vld_q <= '0;
      nm_vld_q <= 1'b0;
      dv_vld_q <= '0;
      done_q   <= 1'b0;
    end else begin
      v1_q     <= accept;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      v5_q     <= v4_q;
      sq_vld_q <= {sq_vld_q[SqrtSteps-1:0], v5_q};
      nm_vld_q <= sq_vld_q[SqrtSteps];
      dv_vld_q <= {dv_vld_q[DivSteps-1:0], nm_vld_q};
      done_q   <= dv_vld_q[DivSteps];
    end
  end

  // Stage 1: the nine component products and the squared radius.
  logic signed [63:0] od1_q [3];
  logic signed [63:0] dd1_q [3];
  logic signed [63:0] oo1_q [3];
  logic [61:0]        rr1_q;
  logic signed [31:0] lo1_q, hi1_q;
  logic               sh1_q;
  logic signed [31:0] o_w [3];
  logic signed [31:0] d_w [3];

  assign o_w[0] = origin_x_i;
  assign o_w[1] = origin_y_i;
  assign o_w[2] = origin_z_i;
  assign d_w[0] = dir_x_i;
  assign d_w[1] = dir_y_i;
  assign d_w[2] = dir_z_i;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      od1_q[i] <= o_w[i] * d_w[i];
      dd1_q[i] <= d_w[i] * d_w[i];
      oo1_q[i] <= o_w[i] * o_w[i];
    end
    rr1_q <= radius_q * radius_q;
    lo1_q <= near_limit_i;
    hi1_q <= far_limit_i;
    sh1_q <= shadow_only_i;
  end

  // Stage 2: A = |d|^2, b = o.d and C = |o|^2 - r^2.
  logic [63:0]        a2_q;
  logic signed [65:0] b2_q, c2_q;
  logic signed [31:0] lo2_q, hi2_q;
  logic               sh2_q;

  always_ff @(posedge clk_i) begin
    a2_q  <= 64'($unsigned(dd1_q[0]) + $unsigned(dd1_q[1]) + $unsigned(dd1_q[2]));
    b2_q  <= 66'(od1_q[0]) + 66'(od1_q[1]) + 66'(od1_q[2]);
    c2_q  <= 66'(oo1_q[0]) + 66'(oo1_q[1]) + 66'(oo1_q[2]) - $signed({4'b0, rr1_q});
    lo2_q <= lo1_q;
    hi2_q <= hi1_q;
    sh2_q <= sh1_q;
  end

  // Stage 3: magnitudes for the unsigned squaring.
  logic [63:0]        a3_q, bm3_q, cm3_q;
  logic signed [65:0] b3_q;
  logic               cn3_q, ok3_q;
  logic signed [31:0] lo3_q, hi3_q;
  logic               sh3_q;

  always_ff @(posedge clk_i) begin
    a3_q  <= a2_q;
    b3_q  <= b2_q;
    bm3_q <= b2_q[65] ? 64'(-b2_q) : b2_q[63:0];
    cn3_q <= c2_q[65];
    cm3_q <= c2_q[65] ? 64'(-c2_q) : c2_q[63:0];
    ok3_q <= a2_q != 64'd0;
    lo3_q <= lo2_q;
    hi3_q <= hi2_q;
    sh3_q <= sh2_q;
  end

  // Stage 4: 32 by 32 partial products of b^2 and A*|C|.
  logic [63:0]        pb00_q, pb01_q, pb11_q;
  logic [63:0]        pa00_q, pa01_q, pa10_q, pa11_q;
  logic [63:0]        a4_q;
  logic signed [65:0] b4_q;
  logic               cn4_q, ok4_q;
  logic signed [31:0] lo4_q, hi4_q;
  logic               sh4_q;

  always_ff @(posedge clk_i) begin
    pb00_q <= bm3_q[31:0] * bm3_q[31:0];
    pb01_q <= bm3_q[31:0] * bm3_q[63:32];
    pb11_q <= bm3_q[63:32] * bm3_q[63:32];
    pa00_q <= a3_q[31:0] * cm3_q[31:0];
    pa01_q <= a3_q[31:0] * cm3_q[63:32];
    pa10_q <= a3_q[63:32] * cm3_q[31:0];
    pa11_q <= a3_q[63:32] * cm3_q[63:32];
    a4_q   <= a3_q;
    b4_q   <= b3_q;
    cn4_q  <= cn3_q;
    ok4_q  <= ok3_q;
    lo4_q  <= lo3_q;
    hi4_q  <= hi3_q;
    sh4_q  <= sh3_q;
  end

  // Stage 5: full 128-bit products.
  logic [127:0]       bsq5_q, acp5_q;
  logic [63:0]        a5_q;
  logic signed [65:0] b5_q;
  logic               cn5_q, ok5_q;
  logic signed [31:0] lo5_q, hi5_q;
  logic               sh5_q;

  always_ff @(posedge clk_i) begin
    bsq5_q <= {pb11_q, 64'b0} + {31'b0, pb01_q, 33'b0} + {64'b0, pb00_q};
    acp5_q <= {pa11_q, 64'b0} + {32'b0, pa01_q, 32'b0} + {32'b0, pa10_q, 32'b0}
              + {64'b0, pa00_q};
    a5_q   <= a4_q;
    b5_q   <= b4_q;
    cn5_q  <= cn4_q;
    ok5_q  <= ok4_q;
    lo5_q  <= lo4_q;
    hi5_q  <= hi4_q;
    sh5_q  <= sh4_q;
  end

  // Stage 6: the quarter discriminant enters the square root chain.
  // Each square is floored to a quarter on its own before they combine.
  sq_t          sq_q [SqrtSteps+1];
  sq_t          sq0_d;
  logic [127:0] bq_w, acq_w;

  always_comb begin
    bq_w         = {2'b0, bsq5_q[127:2]};
    acq_w        = {2'b0, acp5_q[127:2]};
    sq0_d.ok     = ok5_q;
    sq0_d.shadow = sh5_q;
    sq0_d.a      = a5_q;
    sq0_d.b      = b5_q;
    sq0_d.lo     = lo5_q;
    sq0_d.hi     = hi5_q;
    sq0_d.rem    = '0;
    sq0_d.root   = '0;
    if (cn5_q) begin
      sq0_d.v = bq_w + acq_w;
    end else if (bq_w < acq_w) begin
      sq0_d.v  = bq_w;
      sq0_d.ok = 1'b0;
    end else begin
      sq0_d.v = bq_w - acq_w;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q[0] <= sq0_d;
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      sq_q[k+1] <= sqrt_step(sq_q[k]);
    end
  end

  // Numerators -b - s and -b + s, with s twice the root.
  logic signed [67:0] n0_q, n1_q, nb_w, s_w;
  logic [63:0]        anm_q;
  logic               oknm_q, shnm_q;
  logic signed [31:0] lonm_q, hinm_q;

  assign nb_w = -68'(sq_q[SqrtSteps].b);
  assign s_w  = $signed({3'b0, sq_q[SqrtSteps].root, 1'b0});

  always_ff @(posedge clk_i) begin
    n0_q   <= nb_w - s_w;
    n1_q   <= nb_w + s_w;
    anm_q  <= sq_q[SqrtSteps].a;
    oknm_q <= sq_q[SqrtSteps].ok;
    shnm_q <= sq_q[SqrtSteps].shadow;
    lonm_q <= sq_q[SqrtSteps].lo;
    hinm_q <= sq_q[SqrtSteps].hi;
  end

  // Two divider lanes, one for each root.
  dv_t dv_q [DivSteps+1];

  always_ff @(posedge clk_i) begin
    dv_q[0].ok     <= oknm_q;
    dv_q[0].shadow <= shnm_q;
    dv_q[0].a      <= anm_q;
    dv_q[0].lo     <= lonm_q;
    dv_q[0].hi     <= hinm_q;
    dv_q[0].l0     <= lane_init(n0_q, anm_q);
    dv_q[0].l1     <= lane_init(n1_q, anm_q);
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      dv_q[k+1].ok     <= dv_q[k].ok;
      dv_q[k+1].shadow <= dv_q[k].shadow;
      dv_q[k+1].a      <= dv_q[k].a;
      dv_q[k+1].lo     <= dv_q[k].lo;
      dv_q[k+1].hi     <= dv_q[k].hi;
      dv_q[k+1].l0     <= div_step(dv_q[k].l0, dv_q[k].a);
      dv_q[k+1].l1     <= div_step(dv_q[k].l1, dv_q[k].a);
    end
  end

  // Final stage: floor, saturate, and take the nearer root inside the limits.
  logic signed [31:0] t0_w, t1_w, dist_d, dist_q;
  logic               h0_w, h1_w, hit_d, hit_q;

  always_comb begin
    t0_w   = $signed(to_q16(dv_q[DivSteps].l0));
    t1_w   = $signed(to_q16(dv_q[DivSteps].l1));
    h0_w   = dv_q[DivSteps].ok && t0_w > dv_q[DivSteps].lo && t0_w < dv_q[DivSteps].hi;
    h1_w   = dv_q[DivSteps].ok && t1_w > dv_q[DivSteps].lo && t1_w < dv_q[DivSteps].hi;
    hit_d  = h0_w | h1_w;
    dist_d = h0_w ? t0_w : t1_w;
    if (!hit_d || dv_q[DivSteps].shadow) begin
      dist_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    dist_q <= dist_d;
  end

  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign hit_distance_o = dist_q;

endmodule
